// ===== rtl/slfr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared constants, state type and control/status bundles for the
// sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

  localparam int unsigned MAX_PAYLOAD_DEF = 16;

  localparam logic [7:0] SYNC_BYTE        = 8'h2b;
  localparam logic [7:0] BROADCAST_ID     = 8'hff;
  localparam logic [7:0] HIGHEST_PLAIN_ID = 8'd3;

  typedef enum logic [2:0] {
    ST_HUNT,
    ST_WAIT_ID,
    ST_WAIT_LEN,
    ST_FILL,
    ST_TRAIL,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic clear;       // zero fill count and read pointer
    logic load_id;
    logic load_len;
    logic store_byte;
    logic rd_advance;
  } ctrl_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic is_sync;
    logic id_zero;
    logic id_ok;
    logic len_zero;
    logic len_big;
    logic fill_last;   // this data byte completes the payload
    logic rd_last;     // read pointer sits on the final stored byte
  } dp_status_t;

endpackage : slfr_pkg
`default_nettype wire

// ===== rtl/slfr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_ctrl
// Frame parser state machine: sequences header capture, payload fill and
// the read-out of stored bytes.
// ----------------------------------------------------------------------------
module slfr_ctrl (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  wire                 out_stall,
  input  slfr_pkg::dp_status_t sts,
  output slfr_pkg::ctrl_cmd_t  cmd
);

  slfr_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= slfr_pkg::ST_HUNT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd            = '0;
    in_stall       = 1'b0;
    out_valid      = 1'b0;
    case (state_r)
      slfr_pkg::ST_HUNT: begin
        cmd.clear = 1'b1;
        if (in_valid && sts.is_sync) begin
          state_nxt = slfr_pkg::ST_WAIT_ID;
        end
      end
      slfr_pkg::ST_WAIT_ID: begin
        if (in_valid && !sts.id_zero) begin
          if (sts.id_ok) begin
            cmd.load_id = 1'b1;
            state_nxt   = slfr_pkg::ST_WAIT_LEN;
          end else begin
            state_nxt = slfr_pkg::ST_HUNT;
          end
        end
      end
      slfr_pkg::ST_WAIT_LEN: begin
        if (in_valid && !sts.len_zero) begin
          if (sts.len_big) begin
            state_nxt = slfr_pkg::ST_HUNT;
          end else begin
            cmd.load_len = 1'b1;
            state_nxt    = slfr_pkg::ST_FILL;
          end
        end
      end
      slfr_pkg::ST_FILL: begin
        if (in_valid) begin
          cmd.store_byte = 1'b1;
          if (sts.fill_last) begin
            state_nxt = slfr_pkg::ST_TRAIL;
          end
        end
      end
      slfr_pkg::ST_TRAIL: begin
        // checksum byte taken unchecked
        if (in_valid) begin
          state_nxt = slfr_pkg::ST_EMIT_RD;
        end
      end
      slfr_pkg::ST_EMIT_RD: begin
        in_stall  = 1'b1;
        state_nxt = slfr_pkg::ST_EMIT_OUT;
      end
      slfr_pkg::ST_EMIT_OUT: begin
        in_stall  = 1'b1;
        out_valid = 1'b1;
        if (!out_stall) begin
          if (sts.rd_last) begin
            state_nxt = slfr_pkg::ST_HUNT;
          end else begin
            cmd.rd_advance = 1'b1;
            state_nxt      = slfr_pkg::ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_nxt = slfr_pkg::ST_HUNT;
      end
    endcase
  end

endmodule : slfr_ctrl
`default_nettype wire

// ===== rtl/slfr_dpath.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_dpath
// Header registers, payload memory with registered read, fill count and
// read pointer, plus the byte decodes fed back to the controller.
// ----------------------------------------------------------------------------
module slfr_dpath #(
  parameter int unsigned MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire  [7:0]           in_rx_byte,
  input  slfr_pkg::ctrl_cmd_t  cmd,
  output slfr_pkg::dp_status_t sts,
  output logic [7:0]           out_packet_id,
  output logic [4:0]           out_packet_length,
  output logic [3:0]           out_byte_index,
  output logic [7:0]           out_data_byte,
  output logic                 out_last
);

  localparam int unsigned LEN_W = $clog2(MAX_PAYLOAD + 1);
  localparam int unsigned IDX_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  logic [7:0]       mem [MAX_PAYLOAD];
  logic [7:0]       id_r;
  logic [LEN_W-1:0] len_r;
  logic [LEN_W-1:0] fill_r;
  logic [IDX_W-1:0] rd_idx_r;
  logic [7:0]       rd_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r   <= '0;
      rd_idx_r <= '0;
    end else if (cmd.clear) begin
      fill_r   <= '0;
      rd_idx_r <= '0;
    end else begin
      if (cmd.store_byte) begin
        fill_r <= fill_r + LEN_W'(1);
      end
      if (cmd.rd_advance) begin
        rd_idx_r <= rd_idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_id) begin
      id_r <= in_rx_byte;
    end
    if (cmd.load_len) begin
      len_r <= LEN_W'(in_rx_byte);
    end
  end

  // payload store, one write and one registered read port
  always_ff @(posedge clk) begin
    if (cmd.store_byte) begin
      mem[fill_r[IDX_W-1:0]] <= in_rx_byte;
    end
    rd_data_r <= mem[rd_idx_r];
  end

  always_comb begin
    sts.is_sync   = (in_rx_byte == slfr_pkg::SYNC_BYTE);
    sts.id_zero   = (in_rx_byte == 8'd0);
    sts.id_ok     = (in_rx_byte <= slfr_pkg::HIGHEST_PLAIN_ID) ||
                    (in_rx_byte == slfr_pkg::BROADCAST_ID);
    sts.len_zero  = (in_rx_byte == 8'd0);
    sts.len_big   = (in_rx_byte > 8'(MAX_PAYLOAD));
    sts.fill_last = ((fill_r + LEN_W'(1)) == len_r);
    sts.rd_last   = ((LEN_W'(rd_idx_r) + LEN_W'(1)) == len_r);
  end

  assign out_packet_id     = id_r;
  assign out_packet_length = 5'(len_r);
  assign out_byte_index    = 4'(rd_idx_r);
  assign out_data_byte     = rd_data_r;
  assign out_last          = sts.rd_last;

endmodule : slfr_dpath
`default_nettype wire

// ===== rtl/sync_length_frame_receiver.sv =====
// Read-out: after the trailing byte is taken, the controller passes through a
//   memory-read state into a present state that shows the first data byte.
// Throughput: one input byte per cycle while parsing; input stalls while a
//   packet is read out, each result being read from memory, then presented.
// Reset: synchronous, active low; the parser returns to hunting for sync and
//   no result is pending. The payload memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sync_length_frame_receiver
// Deframes sync/id/length/data/checksum packets from a byte stream and
// replays each completed payload as one transaction per data byte.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver #(
  parameter int unsigned MAX_PAYLOAD = slfr_pkg::MAX_PAYLOAD_DEF
) (
  input  wire        clk,
  input  wire        rst_n,
  // received byte channel
  input  wire        in_valid,
  output logic       in_stall,
  input  wire  [7:0] in_rx_byte,
  // result channel
  output logic       out_valid,
  input  wire        out_stall,
  output logic [7:0] out_packet_id,
  output logic [4:0] out_packet_length,
  output logic [3:0] out_byte_index,
  output logic [7:0] out_data_byte,
  output logic       out_last
);

  slfr_pkg::ctrl_cmd_t  cmd;
  slfr_pkg::dp_status_t sts;

  // State machine: hunt -> id -> length -> fill -> checksum -> read-out.
  // Zero id/length bytes are skipped in place; a bad id or an oversize
  // length drops straight back to hunting.
  slfr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Datapath: header registers, payload memory and the read-out pointer.
  // Result fields come straight from registers, so they hold while stalled.
  slfr_dpath #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_rx_byte        (in_rx_byte),
    .cmd               (cmd),
    .sts               (sts),
    .out_packet_id     (out_packet_id),
    .out_packet_length (out_packet_length),
    .out_byte_index    (out_byte_index),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last)
  );

endmodule : sync_length_frame_receiver
`default_nettype wire

// ===== rtl/slfr_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks for the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_stall,
  input wire [7:0] in_rx_byte,
  input wire       out_valid,
  input wire       out_stall,
  input wire [7:0] out_packet_id,
  input wire [4:0] out_packet_length,
  input wire [3:0] out_byte_index,
  input wire [7:0] out_data_byte,
  input wire       out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_index) &&
      $stable(out_data_byte) && $stable(out_packet_id) &&
      $stable(out_packet_length) && $stable(out_last))
    else $error("result changed under stall");

  // stalled input byte holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_rx_byte))
    else $error("input changed under stall");

  // no input taken while a result is shown
  a_in_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open during read-out");

  // after the final transaction the parser is ready for bytes again
  a_last_release: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && out_last |=> !out_valid && !in_stall)
    else $error("parser not released after last byte");

  // read-out steps through consecutive indexes
  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stall && !out_last |=> ##1
      (out_valid && out_byte_index == 4'($past(out_byte_index, 2) + 4'd1)))
    else $error("byte index not consecutive");

endmodule : slfr_checker

bind sync_length_frame_receiver slfr_checker u_slfr_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .in_rx_byte        (in_rx_byte),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_packet_id     (out_packet_id),
  .out_packet_length (out_packet_length),
  .out_byte_index    (out_byte_index),
  .out_data_byte     (out_data_byte),
  .out_last          (out_last)
);
`default_nettype wire

// ===== verif/sync_length_frame_receiver_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_tb
// Drives byte streams into the frame receiver: a short directed run of corner
// cases, then mostly well-formed frames with random content and some noise and
// broken frames. Both handshakes idle at random. A scoreboard predicts the
// replayed payload transactions and checks each one field by field.
// ----------------------------------------------------------------------------
module sync_length_frame_receiver_tb;

  localparam int unsigned MAX_PAYLOAD     = slfr_pkg::MAX_PAYLOAD_DEF;
  localparam int          RESET_CYCLES    = 12;
  localparam int          FRAME_BYTES     = 250;    // random part stops after this many
  localparam int          HOLD_OFF_CYCLES = 300;    // one long receiver hold-off
  localparam int          DRAIN_CYCLES    = 16;
  localparam int          RUN_LIMIT_NS    = 200_000;

  // Directed stream. Comments give the case each group exercises.
  localparam int          NUM_DIRECTED    = 22;
  localparam logic [7:0]  DIRECTED_BYTES [NUM_DIRECTED] = '{
    8'h00, 8'hff,                                  // junk while hunting
    slfr_pkg::SYNC_BYTE, 8'h00, 8'h01, 8'h00, 8'h01, 8'hff, 8'h00,
                                                   // zero id and zero length skipped
    slfr_pkg::SYNC_BYTE, slfr_pkg::SYNC_BYTE,      // sync in the id slot aborts
    slfr_pkg::SYNC_BYTE, 8'hfe,                    // bad id aborts
    slfr_pkg::SYNC_BYTE, slfr_pkg::BROADCAST_ID, 8'h11,
                                                   // length one over the max
    slfr_pkg::SYNC_BYTE, slfr_pkg::HIGHEST_PLAIN_ID, 8'h02, 8'h00, 8'hff, 8'ha5
                                                   // checksum never verified
  };

  typedef struct packed {
    logic [7:0] packet_id;
    logic [4:0] packet_length;
    logic [3:0] byte_index;
    logic [7:0] data_byte;
    logic       last;
  } payload_beat_t;

  // --------------------------------------------------------------------------
  // Scoreboard: tracks the deframing state and queues the payload beats that
  // each trailing byte releases.
  // --------------------------------------------------------------------------
  class frame_scoreboard;
    logic          in_frame;
    logic [7:0]    frame_id;
    logic [4:0]    frame_len;
    logic [4:0]    fill_cnt;
    logic [7:0]    payload [MAX_PAYLOAD];
    payload_beat_t expected_beats [$];
    int            mismatch_count;
    int            beats_seen;

    function void back_to_hunt();
      in_frame  = 1'b0;
      frame_id  = 8'd0;
      frame_len = 5'd0;
      fill_cnt  = 5'd0;
    endfunction

    function new();
      back_to_hunt();
      mismatch_count = 0;
      beats_seen     = 0;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    // Called for every accepted input transaction.
    function void note_byte(input logic [7:0] b);
      payload_beat_t beat;
      int            k;
      if (!in_frame) begin
        if (b == slfr_pkg::SYNC_BYTE) in_frame = 1'b1;
      end else if (frame_id == 8'd0) begin
        // zero id keeps waiting; anything above the plain ids bar broadcast aborts
        if (b > slfr_pkg::HIGHEST_PLAIN_ID && b != slfr_pkg::BROADCAST_ID)
          in_frame = 1'b0;
        else frame_id = b;
      end else if (frame_len == 5'd0) begin
        if (b > MAX_PAYLOAD) begin
          in_frame = 1'b0;
          frame_id = 8'd0;
        end else begin
          frame_len = b[4:0];
        end
      end else if (fill_cnt < frame_len) begin
        payload[fill_cnt[3:0]] = b;
        fill_cnt++;
      end else begin
        // trailing byte: replay the stored payload
        if (fill_cnt == frame_len) begin
          for (k = 0; k < fill_cnt; k++) begin
            beat.packet_id     = frame_id;
            beat.packet_length = fill_cnt;
            beat.byte_index    = k[3:0];
            beat.data_byte     = payload[k];
            beat.last          = (k + 1 == fill_cnt);
            expected_beats.push_back(beat);
          end
        end
        back_to_hunt();
      end
    endfunction

    task report(input string what);
      $display("[%0t] MISMATCH %s", $realtime, what);
      mismatch_count++;
    endtask

    // Called for every accepted result transaction.
    task check_beat(input payload_beat_t got);
      payload_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("unexpected result: id %0h len %0d idx %0d data %0h last %0b",
                         got.packet_id, got.packet_length, got.byte_index,
                         got.data_byte, got.last));
      end else begin
        want = expected_beats.pop_front();
        if (got.packet_id !== want.packet_id)
          report($sformatf("result %0d packet_id %0h, want %0h",
                           beats_seen, got.packet_id, want.packet_id));
        if (got.packet_length !== want.packet_length)
          report($sformatf("result %0d packet_length %0d, want %0d",
                           beats_seen, got.packet_length, want.packet_length));
        if (got.byte_index !== want.byte_index)
          report($sformatf("result %0d byte_index %0d, want %0d",
                           beats_seen, got.byte_index, want.byte_index));
        if (got.data_byte !== want.data_byte)
          report($sformatf("result %0d data_byte %0h, want %0h",
                           beats_seen, got.data_byte, want.data_byte));
        if (got.last !== want.last)
          report($sformatf("result %0d last %0b, want %0b",
                           beats_seen, got.last, want.last));
      end
      beats_seen++;
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and DUT
  // --------------------------------------------------------------------------
  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_valid   = 1'b0;
  logic [7:0] in_rx_byte = 8'h00;
  logic       out_stall  = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_packet_id;
  logic [4:0] out_packet_length;
  logic [3:0] out_byte_index;
  logic [7:0] out_data_byte;
  logic       out_last;

  always #1 clk = ~clk;

  sync_length_frame_receiver u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_packet_id     (out_packet_id),
    .out_packet_length (out_packet_length),
    .out_byte_index    (out_byte_index),
    .out_data_byte     (out_data_byte),
    .out_last          (out_last)
  );

  frame_scoreboard sb = new();

  // Idle pattern shared by both sides: calm stretches with no gaps alternate
  // with busy stretches where gaps are mostly short and now and then long.
  function automatic int pick_gap(inout bit calm, inout int phase_left);
    int r;
    if (phase_left == 0) begin
      calm       = !calm;
      phase_left = $urandom_range(30, 150);
    end else begin
      phase_left--;
    end
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  bit src_calm       = 1'b0;
  int src_phase_left = 0;
  bit random_phase   = 1'b0;   // arms the long receiver hold-off
  int frame_bytes_sent;

  // One input transaction. Valid is written once per falling edge: low for
  // each gap cycle, then high with the byte until it is taken.
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(src_calm, src_phase_left);
    @(negedge clk);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall);
    sb.note_byte(b);
  endtask

  // Sync, id, length, payload and checksum, with the odd skipped zero id or
  // zero length thrown in. Only the first cut bytes go out, so a small cut
  // gives a broken frame. Payload is only sent for lengths within range.
  task automatic send_frame(input logic [7:0] id, input logic [7:0] len, input int cut);
    logic [7:0] frame_q [$];
    int         n;
    frame_q.push_back(slfr_pkg::SYNC_BYTE);
    if ($urandom_range(0, 9) == 0) frame_q.push_back(8'h00);
    frame_q.push_back(id);
    if ($urandom_range(0, 9) == 0) frame_q.push_back(8'h00);
    frame_q.push_back(len);
    if (len <= MAX_PAYLOAD) begin
      repeat (len) frame_q.push_back(8'($urandom));
      frame_q.push_back(8'($urandom));   // checksum, any value
    end
    for (n = 0; n < frame_q.size() && n < cut; n++) begin
      send_byte(frame_q[n]);
      frame_bytes_sent++;
    end
  endtask

  function automatic logic [7:0] good_id();
    if ($urandom_range(0, 3) == 0) return slfr_pkg::BROADCAST_ID;
    return 8'($urandom_range(1, slfr_pkg::HIGHEST_PLAIN_ID));
  endfunction

  function automatic logic [7:0] good_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 8'($urandom_range(1, 4));
    if (r < 90) return 8'($urandom_range(1, MAX_PAYLOAD));
    return 8'(MAX_PAYLOAD);
  endfunction

  initial begin : stimulus
    int i;
    int r;
    frame_bytes_sent = 0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < NUM_DIRECTED; i++) send_byte(DIRECTED_BYTES[i]);

    random_phase = 1'b1;
    // a full-size frame first so the largest payload is always covered
    send_frame(8'd2, 8'(MAX_PAYLOAD), 1 << 30);
    while (frame_bytes_sent < FRAME_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 70) begin
        send_frame(good_id(), good_len(), 1 << 30);
      end else if (r < 78) begin
        // line noise while hunting
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
      end else if (r < 84) begin
        // id outside the accepted set
        send_frame(8'($urandom_range(slfr_pkg::HIGHEST_PLAIN_ID + 1,
                                     slfr_pkg::BROADCAST_ID - 1)),
                   good_len(), 1 << 30);
      end else if (r < 90) begin
        // oversize length
        send_frame(good_id(), 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1 << 30);
      end else begin
        // truncated frame; whatever follows lands in its fields
        send_frame(good_id(), good_len(), $urandom_range(1, 8));
      end
    end
    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then wait out the drain period in case something stray turns up
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver side: random stall, plus one long hold-off once results start
  // flowing in the random part, so the payload replay backs up into the input.
  // --------------------------------------------------------------------------
  bit snk_calm       = 1'b1;
  int snk_phase_left = 0;
  int stall_left     = 0;
  bit hold_off_done  = 1'b0;

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        if (!hold_off_done && random_phase && out_valid) begin
          hold_off_done = 1'b1;
          stall_left    = HOLD_OFF_CYCLES;
        end else begin
          stall_left = pick_gap(snk_calm, snk_phase_left);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Result monitor: sample on the rising edge, before the DUT updates.
  payload_beat_t seen_beat;
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      seen_beat.packet_id     = out_packet_id;
      seen_beat.packet_length = out_packet_length;
      seen_beat.byte_index    = out_byte_index;
      seen_beat.data_byte     = out_data_byte;
      seen_beat.last          = out_last;
      sb.check_beat(seen_beat);
    end
  end

  // Watchdog
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== sync_length_frame_receiver.f =====
rtl/slfr_pkg.sv
rtl/slfr_ctrl.sv
rtl/slfr_dpath.sv
rtl/sync_length_frame_receiver.sv
rtl/slfr_checker.sv
verif/sync_length_frame_receiver_tb.sv
